FILE: src/servo_packet_responder_core_assert.svh
// assertion macros for the servo packet responder
`ifndef SERVO_PACKET_RESPONDER_CORE_ASSERT_SVH
`define SERVO_PACKET_RESPONDER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/spr_pkg.sv
// constants, types and reply microcode for the servo packet responder
package spr_pkg;

	localparam int MAX_READ_LEN = 32;
	localparam int MAX_FRAME    = 256;
	localparam int MAX_DATA     = (MAX_READ_LEN > 6) ? MAX_READ_LEN : 6;
	localparam int ND_W         = $clog2(MAX_DATA + 1);
	localparam int BC_W         = $clog2(MAX_FRAME + 2);
	localparam int PC_W         = 3;

	localparam logic [7:0] HDR_BYTE      = 8'hFF;
	localparam logic [7:0] OP_PING       = 8'h01;
	localparam logic [7:0] OP_READ       = 8'h02;
	localparam logic [7:0] ADDR_POSITION = 8'h24;
	localparam logic [7:0] ST_OK         = 8'h00;
	localparam logic [7:0] ST_CHECKSUM   = 8'h04;
	localparam logic [7:0] ST_INSTR      = 8'h07;
	localparam logic [7:0] LEN_SHORT     = 8'h02;
	localparam logic [7:0] LEN_PING      = 8'h07;
	localparam logic [7:0] ZERO_BYTE     = 8'h00;

	localparam logic [1:0] REG_POSITION = 2'd0;
	localparam logic [1:0] REG_MODEL    = 2'd1;
	localparam logic [1:0] REG_FIRMWARE = 2'd2;

	localparam logic [PC_W-1:0] STEP_HDR0   = 3'd0;
	localparam logic [PC_W-1:0] STEP_HDR1   = 3'd1;
	localparam logic [PC_W-1:0] STEP_ID     = 3'd2;
	localparam logic [PC_W-1:0] STEP_LEN    = 3'd3;
	localparam logic [PC_W-1:0] STEP_STATUS = 3'd4;
	localparam logic [PC_W-1:0] STEP_DATA   = 3'd5;
	localparam logic [PC_W-1:0] STEP_CHK    = 3'd6;

	typedef enum logic [2:0] {
		SRC_HDR,
		SRC_ID,
		SRC_LEN,
		SRC_STATUS,
		SRC_DATA,
		SRC_CHK
	} src_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_IF_NODATA,
		JMP_WHILE_DATA,
		JMP_END
	} jmp_t;

	typedef enum logic [1:0] {
		DK_ZERO,
		DK_PING,
		DK_POS
	} dkind_t;

	typedef struct packed {
		src_t            src;
		logic            add_sum;
		logic            last;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t c;
		c = '{src: SRC_HDR, add_sum: 1'b0, last: 1'b0, jmp: JMP_END, target: STEP_HDR0};
		case (pc)
			STEP_HDR0:   c = '{SRC_HDR,    1'b0, 1'b0, JMP_NEXT,       STEP_HDR0};
			STEP_HDR1:   c = '{SRC_HDR,    1'b0, 1'b0, JMP_NEXT,       STEP_HDR0};
			STEP_ID:     c = '{SRC_ID,     1'b1, 1'b0, JMP_NEXT,       STEP_HDR0};
			STEP_LEN:    c = '{SRC_LEN,    1'b1, 1'b0, JMP_NEXT,       STEP_HDR0};
			STEP_STATUS: c = '{SRC_STATUS, 1'b1, 1'b0, JMP_IF_NODATA,  STEP_CHK};
			STEP_DATA:   c = '{SRC_DATA,   1'b1, 1'b0, JMP_WHILE_DATA, STEP_DATA};
			STEP_CHK:    c = '{SRC_CHK,    1'b0, 1'b1, JMP_END,        STEP_HDR0};
			default:     c = '{SRC_HDR,    1'b0, 1'b0, JMP_END,        STEP_HDR0};
		endcase
		return c;
	endfunction

endpackage

FILE: src/servo_packet_responder_core.sv
// servo packet responder: frame parser and microcoded reply sequencer
//
// Received bytes are taken one per cycle while no reply is being sent. On the
// frame-end byte the frame is checked and, if it calls for an answer, a short
// microprogram (header, id, length, status, data loop, checksum) emits the
// reply one byte per cycle, while the sink accepts, through a registered output;
// a reply of n data bytes is 6 + n bytes long (6 to 6 + MAX_READ_LEN), and the
// input side holds tready low until the checksum byte has been loaded.
// Configuration writes are always taken.
module servo_packet_responder_core
	import spr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte
	input  logic        s_axis_tlast,   // frame_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // tx_byte
	output logic        m_axis_tlast,   // tx_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration
	logic [9:0]  position_q;
	logic [15:0] model_q;
	logic [7:0]  firmware_q;

	// frame parser state
	logic [BC_W-1:0] byte_count_q;
	logic            header_ok_q;
	logic [7:0]      servo_id_q;
	logic [7:0]      frame_length_q;
	logic [7:0]      opcode_q;
	logic [7:0]      first_param_q;
	logic [7:0]      second_param_q;
	logic [7:0]      running_sum_q;

	// reply sequencer
	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic [7:0]      rep_id_q;
	logic [7:0]      rep_len_q;
	logic [7:0]      rep_status_q;
	logic [ND_W-1:0] ndata_q;
	logic [ND_W-1:0] didx_q;
	dkind_t          kind_q;
	logic [7:0]      sum_q;

	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;

	logic            in_xfer;
	logic            reply_go;
	logic            chk_ok;
	logic [7:0]      new_len;
	logic [7:0]      new_status;
	logic [ND_W-1:0] new_ndata;
	dkind_t          new_kind;
	logic            adv;
	ctrl_t           ctrl;
	logic [7:0]      data_byte;
	logic [7:0]      seq_byte;
	logic [ND_W-1:0] didx_inc;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !busy_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	// frame check on the frame-end byte
	assign chk_ok   = (s_axis_tdata == ~running_sum_q);
	assign reply_go = in_xfer && s_axis_tlast && header_ok_q
		&& (byte_count_q >= BC_W'(5)) && (byte_count_q <= BC_W'(MAX_FRAME - 1));

	always_comb begin
		new_len    = LEN_SHORT;
		new_status = ST_INSTR;
		new_ndata  = '0;
		new_kind   = DK_ZERO;
		if (!chk_ok) begin
			new_status = ST_CHECKSUM;
		end else if (opcode_q == OP_PING) begin
			new_len    = LEN_PING;
			new_status = ST_OK;
			new_ndata  = ND_W'(6);
			new_kind   = DK_PING;
		end else if (opcode_q == OP_READ) begin
			if ((byte_count_q >= BC_W'(7)) && (second_param_q <= 8'(MAX_READ_LEN))) begin
				new_len    = second_param_q + 8'd2;
				new_status = ST_OK;
				new_ndata  = ND_W'(second_param_q);
				if ((first_param_q == ADDR_POSITION) && (second_param_q == 8'd2)) begin
					new_kind = DK_POS;
				end
			end
		end
	end

	// microcode fetch and datapath
	assign ctrl     = ucode(pc_q);
	assign adv      = busy_q && (!out_valid_q || m_axis_tready);
	assign didx_inc = didx_q + ND_W'(1);

	always_comb begin
		data_byte = ZERO_BYTE;
		case (kind_q)
			DK_PING: begin
				if (didx_q == ND_W'(0)) data_byte = model_q[7:0];
				else if (didx_q == ND_W'(1)) data_byte = model_q[15:8];
				else if (didx_q == ND_W'(2)) data_byte = firmware_q;
			end
			DK_POS: begin
				if (didx_q == ND_W'(0)) data_byte = position_q[7:0];
				else if (didx_q == ND_W'(1)) data_byte = {6'd0, position_q[9:8]};
			end
			default: data_byte = ZERO_BYTE;
		endcase
	end

	always_comb begin
		case (ctrl.src)
			SRC_HDR:    seq_byte = HDR_BYTE;
			SRC_ID:     seq_byte = rep_id_q;
			SRC_LEN:    seq_byte = rep_len_q;
			SRC_STATUS: seq_byte = rep_status_q;
			SRC_DATA:   seq_byte = data_byte;
			SRC_CHK:    seq_byte = ~sum_q;
			default:    seq_byte = HDR_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= 10'd512;
			model_q    <= 16'd513;
			firmware_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POSITION: position_q <= cfg_data[9:0];
				REG_MODEL:    model_q    <= cfg_data;
				REG_FIRMWARE: firmware_q <= cfg_data[7:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			header_ok_q    <= 1'b1;
			servo_id_q     <= '0;
			frame_length_q <= '0;
			opcode_q       <= '0;
			first_param_q  <= '0;
			second_param_q <= '0;
			running_sum_q  <= '0;
		end else if (in_xfer) begin
			if (s_axis_tlast) begin
				byte_count_q   <= '0;
				header_ok_q    <= 1'b1;
				servo_id_q     <= '0;
				frame_length_q <= '0;
				opcode_q       <= '0;
				first_param_q  <= '0;
				second_param_q <= '0;
				running_sum_q  <= '0;
			end else begin
				if ((byte_count_q < BC_W'(2)) && (s_axis_tdata != HDR_BYTE)) begin
					header_ok_q <= 1'b0;
				end
				case (byte_count_q)
					BC_W'(2): servo_id_q     <= s_axis_tdata;
					BC_W'(3): frame_length_q <= s_axis_tdata;
					BC_W'(4): opcode_q       <= s_axis_tdata;
					BC_W'(5): first_param_q  <= s_axis_tdata;
					BC_W'(6): second_param_q <= s_axis_tdata;
					default:  ;
				endcase
				if (byte_count_q >= BC_W'(2)) begin
					running_sum_q <= running_sum_q + s_axis_tdata;
				end
				if (byte_count_q <= BC_W'(MAX_FRAME)) begin
					byte_count_q <= byte_count_q + BC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pc_q         <= STEP_HDR0;
			rep_id_q     <= '0;
			rep_len_q    <= '0;
			rep_status_q <= '0;
			ndata_q      <= '0;
			didx_q       <= '0;
			kind_q       <= DK_ZERO;
			sum_q        <= '0;
		end else if (reply_go) begin
			busy_q       <= 1'b1;
			pc_q         <= STEP_HDR0;
			rep_id_q     <= servo_id_q;
			rep_len_q    <= new_len;
			rep_status_q <= new_status;
			ndata_q      <= new_ndata;
			didx_q       <= '0;
			kind_q       <= new_kind;
			sum_q        <= '0;
		end else if (adv) begin
			if (ctrl.add_sum) begin
				sum_q <= sum_q + seq_byte;
			end
			if (ctrl.src == SRC_DATA) begin
				didx_q <= didx_inc;
			end
			case (ctrl.jmp)
				JMP_NEXT:       pc_q <= pc_q + PC_W'(1);
				JMP_IF_NODATA:  pc_q <= (ndata_q == '0) ? ctrl.target : pc_q + PC_W'(1);
				JMP_WHILE_DATA: pc_q <= (didx_inc != ndata_q) ? ctrl.target : pc_q + PC_W'(1);
				JMP_END:        busy_q <= 1'b0;
				default:        busy_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
			out_byte_q  <= seq_byte;
			out_last_q  <= ctrl.last;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

`include "servo_packet_responder_core_assert.svh"

	`SPR_ASSERT_NEXT(a_reply_starts_at_header, reply_go, busy_q && (pc_q == STEP_HDR0),
		"reply did not start at the header step")
	`SPR_ASSERT_NEXT(a_checksum_ends_reply, adv && (pc_q == STEP_CHK),
		m_axis_tvalid && m_axis_tlast && !busy_q, "checksum step did not end the reply")
	`SPR_ASSERT_NOW(a_data_index_bounded, busy_q, didx_q <= ndata_q,
		"data index ran past the data count")

endmodule
